@@ hw/rtl/dbq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbq_pkg: shared types and codes for the byte deque
// request and result beat layouts, request and status codes, fsm states and
// the command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package dbq_pkg;

    // request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_SEARCH     = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam int unsigned OCC_W = 5;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       data_out;
        logic             found;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
        logic [7:0]       front_value;
        logic [7:0]       back_value;
    } out_item_t;

    typedef enum logic [2:0] {
        CTRL_IDLE,
        CTRL_EXEC,
        CTRL_LOAD,
        CTRL_SCAN,
        CTRL_REPLY
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
        logic scan;
    } dp_cmd_t;

    typedef struct packed {
        logic need_load;
        logic need_scan;
        logic scan_done;
    } dp_stat_t;

endpackage

@@ hw/rtl/byte_deque_with_search_core.sv @@
`timescale 1ns / 1ps
// every request passes through execute and reply; a pop on a nonempty queue adds a reload
//   of the new end from the slot ram, and a search on a nonempty queue adds a scan of the
//   occupied slots, which a match ends early
// busy drops in the cycle after done, so a new request is taken only once the last is through
// the scan reads one slot per cycle through the single read port of the slot ram
// reset: asynchronous, clears the pointers and the count (queue empty); slots are not cleared
// ----------------------------------------------------------------------------
// byte_deque_with_search_core: bounded byte deque with search
// ring buffer of DEPTH slots with push and pop at both ends and a linear
// value search; every request beat yields one result beat
// ----------------------------------------------------------------------------
module byte_deque_with_search_core
    import dbq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  request,
    output logic      busy,
    output logic      done,
    output out_item_t response
);

    // command and status bundles between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t dp_stat;

    // sequencer: idle, execute, optional end reload or scan, reply
    dbq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    // pointers, end registers, slot ram and search engine
    dbq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .request  (request),
        .dp_stat  (dp_stat),
        .response (response)
    );

    // a result beat is only shown while the block is still busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // an accepted beat never produces its result in the next cycle
    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("result strobe right after accept");

    // at most one datapath command at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec, cmd.load, cmd.scan}))
        else $error("overlapping datapath commands");

    // a pop on an empty queue reports a zero byte
    a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status == STAT_EMPTY)) |-> (response.data_out == 8'd0))
        else $error("nonzero data on empty pop");

endmodule

@@ hw/rtl/dbq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbq_ram: generic single write, single read ram
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module dbq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/dbq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbq_ctrl: request sequencer
// steps each request through execute, an optional slot reload or scan, and reply
// ----------------------------------------------------------------------------
module dbq_ctrl
    import dbq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                if (start)
                begin
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                priority if (dp_stat.need_scan)
                begin
                    state_next = CTRL_SCAN;
                end
                else if (dp_stat.need_load)
                begin
                    state_next = CTRL_LOAD;
                end
                else
                begin
                    state_next = CTRL_REPLY;
                end
            end
            CTRL_LOAD:
            begin
                state_next = CTRL_REPLY;
            end
            CTRL_SCAN:
            begin
                if (dp_stat.scan_done)
                begin
                    state_next = CTRL_REPLY;
                end
            end
            CTRL_REPLY:
            begin
                state_next = CTRL_IDLE;
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            CTRL_EXEC:  cmd.exec = 1'b1;
            CTRL_LOAD:  cmd.load = 1'b1;
            CTRL_SCAN:  cmd.scan = 1'b1;
            CTRL_REPLY: done = 1'b1;
            default:    busy = 1'b1;
        endcase
    end

endmodule

@@ hw/rtl/dbq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbq_datapath: ring buffer pointers, end registers and search engine
// front and back bytes live in registers; the slot ram is read only to
// reload an end after a pop and to scan for a search
// ----------------------------------------------------------------------------
module dbq_datapath
    import dbq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  in_item_t  request,
    output dp_stat_t  dp_stat,
    output out_item_t response
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] pos);
        return (pos == LAST_POS) ? '0 : pos + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] pos);
        return (pos == '0) ? LAST_POS : pos - AW'(1);
    endfunction

    // control state
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_left_reg, scan_left_next;
    logic          pend_reg, pend_next;

    // payload
    logic [2:0]    req_type_reg, req_type_next;
    logic [7:0]    value_reg, value_next;
    logic [7:0]    front_reg, front_next;
    logic [7:0]    back_reg, back_next;
    logic [7:0]    data_reg, data_next;
    logic          found_reg, found_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] scan_pos_reg, scan_pos_next;
    logic          load_front_reg, load_front_next;

    // slot ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic is_empty;
    logic is_full;
    logic is_pop;
    logic [CW+OCC_W-1:0] occ_ext;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);
    assign is_pop   = (req_type_reg == REQ_POP_FRONT) || (req_type_reg == REQ_POP_BACK);

    assign dp_stat.need_load = is_pop && !is_empty;
    assign dp_stat.need_scan = (req_type_reg == REQ_SEARCH) && !is_empty;
    assign dp_stat.scan_done = found_reg || ((scan_left_reg == '0) && !pend_reg);

    dbq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_left_next  = scan_left_reg;
        pend_next       = pend_reg;
        req_type_next   = req_type_reg;
        value_next      = value_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        data_next       = data_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        scan_pos_next   = scan_pos_reg;
        load_front_next = load_front_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_re          = 1'b0;
        ram_raddr       = ring_inc(head_reg);

        if (cmd.capture)
        begin
            req_type_next = request.req_type;
            value_next    = request.value;
        end

        if (cmd.exec)
        begin
            data_next   = '0;
            found_next  = 1'b0;
            status_next = STAT_OK;
            unique case (req_type_reg)
                REQ_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        head_next  = ring_dec(head_reg);
                        ram_we     = 1'b1;
                        ram_waddr  = ring_dec(head_reg);
                        count_next = count_reg + CW'(1);
                        front_next = value_reg;
                        if (is_empty)
                        begin
                            back_next = value_reg;
                        end
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        tail_next  = ring_inc(tail_reg);
                        ram_we     = 1'b1;
                        ram_waddr  = tail_reg;
                        count_next = count_reg + CW'(1);
                        back_next  = value_reg;
                        if (is_empty)
                        begin
                            front_next = value_reg;
                        end
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        // fetch the byte that becomes the new front
                        data_next       = front_reg;
                        head_next       = ring_inc(head_reg);
                        count_next      = count_reg - CW'(1);
                        ram_re          = 1'b1;
                        ram_raddr       = ring_inc(head_reg);
                        load_front_next = 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        // fetch the byte that becomes the new back
                        data_next       = back_reg;
                        tail_next       = ring_dec(tail_reg);
                        count_next      = count_reg - CW'(1);
                        ram_re          = 1'b1;
                        ram_raddr       = ring_dec(ring_dec(tail_reg));
                        load_front_next = 1'b0;
                    end
                end
                REQ_SEARCH:
                begin
                    scan_pos_next  = head_reg;
                    scan_left_next = count_reg;
                    pend_next      = 1'b0;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end

        if (cmd.load)
        begin
            if (load_front_reg)
            begin
                front_next = ram_rdata;
            end
            else
            begin
                back_next = ram_rdata;
            end
        end

        // one slot read issued and one compared per cycle
        if (cmd.scan)
        begin
            if (scan_left_reg != '0)
            begin
                ram_re         = 1'b1;
                ram_raddr      = scan_pos_reg;
                scan_pos_next  = ring_inc(scan_pos_reg);
                scan_left_next = scan_left_reg - CW'(1);
                pend_next      = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
            if (pend_reg && (ram_rdata == value_reg))
            begin
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_left_reg <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_left_reg <= scan_left_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        value_reg      <= value_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        data_reg       <= data_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        scan_pos_reg   <= scan_pos_next;
        load_front_reg <= load_front_next;
    end

    assign occ_ext = {{OCC_W{1'b0}}, count_reg};

    assign response.data_out    = data_reg;
    assign response.found       = found_reg;
    assign response.status      = status_reg;
    assign response.occupancy   = occ_ext[OCC_W-1:0];
    assign response.front_value = is_empty ? 8'd0 : front_reg;
    assign response.back_value  = is_empty ? 8'd0 : back_reg;

endmodule

@@ sim/tb_byte_deque_with_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_deque_with_search_core: self-checking bench for the byte deque
// a short directed walk over the empty, full and wrap-around corners, then
// phased random traffic; every result beat is checked field by field against
// the typed result of its walk row or else a behavioral deque kept inside the bench
// ----------------------------------------------------------------------------
module tb_byte_deque_with_search_core
    import dbq_pkg::*;
();

    localparam int unsigned DEPTH          = 16;
    localparam int unsigned RAND_ITEMS     = 800;   // random requests that do real work
    localparam int unsigned CALM_TAIL      = 120;   // last random requests go back to back
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no beat in either direction
    localparam int unsigned SETTLE_CYCLES  = 40;    // wait after the last expected result beat

    // request codes the block treats as no operation
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    // traffic mixes for the random part
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_SEARCH
    } traffic_mix_t;

    // one row of the directed walk: a request repeated reps times, with the
    // result typed in where it is obvious
    typedef struct packed {
        logic [2:0] req;
        logic [7:0] val;
        logic [4:0] reps;
        logic       typed;
        out_item_t  want;
    } walk_row_t;

    localparam out_item_t NO_WANT  = '0;
    localparam int unsigned WALK_ROWS = 17;

    walk_row_t walk_rows [WALK_ROWS] = '{
        // empty queue right after reset
        {REQ_POP_FRONT,  8'h00, 5'd1, 1'b1, {8'h00, 1'b0, STAT_EMPTY, 5'd0, 8'h00, 8'h00}},
        {REQ_POP_BACK,   8'h00, 5'd1, 1'b1, {8'h00, 1'b0, STAT_EMPTY, 5'd0, 8'h00, 8'h00}},
        {REQ_SEARCH,     8'h00, 5'd1, 1'b1, {8'h00, 1'b0, STAT_OK,    5'd0, 8'h00, 8'h00}},
        {REQ_UNUSED_LO,  8'h00, 5'd1, 1'b1, {8'h00, 1'b0, STAT_OK,    5'd0, 8'h00, 8'h00}},
        // extremes of the byte, front push wraps the head below zero
        {REQ_PUSH_BACK,  8'h00, 5'd1, 1'b1, {8'h00, 1'b0, STAT_OK,    5'd1, 8'h00, 8'h00}},
        {REQ_PUSH_FRONT, 8'hFF, 5'd1, 1'b1, {8'h00, 1'b0, STAT_OK,    5'd2, 8'hFF, 8'h00}},
        {REQ_SEARCH,     8'hFF, 5'd1, 1'b1, {8'h00, 1'b1, STAT_OK,    5'd2, 8'hFF, 8'h00}},
        {REQ_SEARCH,     8'h80, 5'd1, 1'b0, NO_WANT},
        {REQ_UNUSED_HI,  8'h5A, 5'd1, 1'b0, NO_WANT},
        {REQ_POP_BACK,   8'h00, 5'd1, 1'b1, {8'h00, 1'b0, STAT_OK,    5'd1, 8'hFF, 8'hFF}},
        {REQ_POP_FRONT,  8'h00, 5'd1, 1'b1, {8'hFF, 1'b0, STAT_OK,    5'd0, 8'h00, 8'h00}},
        // fill from both ends, then push into the full queue
        {REQ_PUSH_FRONT, 8'h01, 5'd8, 1'b0, NO_WANT},
        {REQ_PUSH_BACK,  8'hFE, 5'd8, 1'b0, NO_WANT},
        {REQ_PUSH_BACK,  8'h33, 5'd1, 1'b1, {8'h00, 1'b0, STAT_FULL,  5'd16, 8'h01, 8'hFE}},
        {REQ_PUSH_FRONT, 8'h33, 5'd1, 1'b1, {8'h00, 1'b0, STAT_FULL,  5'd16, 8'h01, 8'hFE}},
        // match halfway through the full queue, then a miss over a full scan
        {REQ_SEARCH,     8'hFE, 5'd1, 1'b0, NO_WANT},
        {REQ_SEARCH,     8'h33, 5'd1, 1'b0, NO_WANT}
    };

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  request;
    logic      busy;
    logic      done;
    out_item_t response;

    // typed expectation travels with the request beat
    logic      typed_check;
    out_item_t typed_result;

    // behavioral deque
    logic [7:0]  deque_slots [DEPTH];
    int unsigned deque_head;
    int unsigned deque_fill;

    out_item_t   expected_results [$];
    out_item_t   next_result;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    byte_deque_with_search_core #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // applies one request to the behavioral deque and returns its result beat
    function automatic out_item_t deque_apply(input in_item_t rq);
        out_item_t   res;
        int unsigned idx;
        res = '0;
        case (rq.req_type)
            REQ_PUSH_FRONT:
            begin
                if (deque_fill >= DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    deque_head = (deque_head + DEPTH - 1) % DEPTH;
                    deque_slots[deque_head] = rq.value;
                    deque_fill++;
                end
            end
            REQ_PUSH_BACK:
            begin
                if (deque_fill >= DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    deque_slots[(deque_head + deque_fill) % DEPTH] = rq.value;
                    deque_fill++;
                end
            end
            REQ_POP_FRONT:
            begin
                if (deque_fill == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.data_out = deque_slots[deque_head];
                    deque_head = (deque_head + 1) % DEPTH;
                    deque_fill--;
                end
            end
            REQ_POP_BACK:
            begin
                if (deque_fill == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.data_out = deque_slots[(deque_head + deque_fill - 1) % DEPTH];
                    deque_fill--;
                end
            end
            REQ_SEARCH:
            begin
                for (idx = 0; idx < deque_fill; idx++)
                    if (deque_slots[(deque_head + idx) % DEPTH] == rq.value)
                        res.found = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.occupancy = OCC_W'(deque_fill);
        if (deque_fill != 0)
        begin
            res.front_value = deque_slots[deque_head];
            res.back_value  = deque_slots[(deque_head + deque_fill - 1) % DEPTH];
        end
        return res;
    endfunction

    task automatic compare_result(input out_item_t got, input out_item_t want);
        if (got.data_out !== want.data_out)
            note_mismatch($sformatf("data_out %h, expected %h", got.data_out, want.data_out));
        if (got.found !== want.found)
            note_mismatch($sformatf("found %b, expected %b", got.found, want.found));
        if (got.status !== want.status)
            note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.occupancy !== want.occupancy)
            note_mismatch($sformatf("occupancy %0d, expected %0d",
                                    got.occupancy, want.occupancy));
        if (got.front_value !== want.front_value)
            note_mismatch($sformatf("front_value %h, expected %h",
                                    got.front_value, want.front_value));
        if (got.back_value !== want.back_value)
            note_mismatch($sformatf("back_value %h, expected %h",
                                    got.back_value, want.back_value));
    endtask

    // result beats are checked before the request beat of the same edge is
    // predicted, so the order inside this block is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("result beat with nothing expected");
                else
                    compare_result(response, expected_results.pop_front());
            end
            if (start && !busy)
            begin
                next_result = deque_apply(request);
                expected_results.push_back(typed_check ? typed_result : next_result);
            end
        end
    end

    // watchdog: any beat in either direction restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // holds one request beat until accepted; a gap lowers start first
    task automatic send_request(input logic [2:0] code, input logic [7:0] val,
                                input logic typed, input out_item_t want,
                                input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        request        <= '{req_type: code, value: val};
        typed_check    <= typed;
        typed_result   <= want;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int unsigned  row;
        int unsigned  rep;
        int unsigned  sent;
        int unsigned  pick;
        int unsigned  push_pct;
        int unsigned  pop_pct;
        int unsigned  search_pct;
        int unsigned  mix_left;
        int unsigned  gap;
        logic         mix_idles;
        traffic_mix_t mix;
        logic [2:0]   code;
        logic [7:0]   val;

        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        typed_check    = 1'b0;
        typed_result   = '0;
        deque_head     = 0;
        deque_fill     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        next_result    = '0;
        foreach (deque_slots[i])
            deque_slots[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk
        for (row = 0; row < WALK_ROWS; row++)
            for (rep = 0; rep < walk_rows[row].reps; rep++)
            begin
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
                send_request(walk_rows[row].req, walk_rows[row].val,
                             walk_rows[row].typed, walk_rows[row].want, gap);
            end

        // random phases: fill-heavy runs reach the full corner, drain-heavy
        // runs the empty one; searches often ask for a stored byte
        sent     = 0;
        mix_left = 0;
        mix      = MIX_BALANCED;
        mix_idles = 1'b0;
        while (sent < RAND_ITEMS)
        begin
            if (mix_left == 0)
            begin
                mix       = traffic_mix_t'($urandom_range(0, 3));
                mix_left  = $urandom_range(8, 40);
                mix_idles = 1'($urandom_range(0, 1));
            end
            mix_left--;
            case (mix)
                MIX_FILL:     begin push_pct = 65; pop_pct = 15; search_pct = 16; end
                MIX_DRAIN:    begin push_pct = 15; pop_pct = 65; search_pct = 16; end
                MIX_BALANCED: begin push_pct = 38; pop_pct = 38; search_pct = 20; end
                default:      begin push_pct = 20; pop_pct = 20; search_pct = 56; end
            endcase

            pick = $urandom_range(0, 99);
            val  = 8'($urandom_range(0, 255));
            if (pick < push_pct)
                code = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else if (pick < push_pct + pop_pct)
                code = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
            else if (pick < push_pct + pop_pct + search_pct)
            begin
                code = REQ_SEARCH;
                if (deque_fill != 0 && $urandom_range(0, 1))
                    val = deque_slots[(deque_head + $urandom_range(0, deque_fill - 1)) % DEPTH];
            end
            else
                code = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));

            // idle bursts stop for the tail of the run
            gap = 0;
            if (mix_idles && sent < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 10);

            send_request(code, val, 1'b0, NO_WANT, gap);
            if (code < REQ_UNUSED_LO)
                sent++;
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ byte_deque_with_search_core.f @@
hw/rtl/dbq_pkg.sv
hw/rtl/dbq_ram.sv
hw/rtl/dbq_ctrl.sv
hw/rtl/dbq_datapath.sv
hw/rtl/byte_deque_with_search_core.sv
sim/tb_byte_deque_with_search_core.sv
